[hw/rtl/masked_stream_statistics_core_defines.svh]
// Assertion macros shared by the masked stream statistics RTL.
`ifndef MASKED_STREAM_STATISTICS_CORE_DEFINES_SVH
`define MASKED_STREAM_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSSTAT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("masked stream statistics check failed");

// Next-cycle implication, checked outside reset.
`define MSSTAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("masked stream statistics check failed");

`endif

[hw/rtl/msstat_pkg.sv]
// Types and constants of the masked stream statistics block.
`timescale 1ns / 1ps
package msstat_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 16;
   localparam int SUM_W    = 32;
   localparam int SQ_W     = 46;
   localparam int FRAC_W   = 8;
   localparam int FIX_W    = 24;
   localparam int Q_DEPTH  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       masked;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]         valid_count;
      logic signed [SUM_W-1:0]    total;
      logic signed [SAMPLE_W-1:0] smallest;
      logic signed [SAMPLE_W-1:0] largest;
      logic signed [FIX_W-1:0]    average;
      logic [FIX_W-1:0]           deviation;
      logic                       overflow;
   } rsp_type;

   // Run totals handed from the front to the back.
   typedef struct packed {
      logic [COUNT_W-1:0]         count;
      logic signed [SUM_W-1:0]    sum;
      logic [SQ_W-1:0]            sumsq;
      logic signed [SAMPLE_W-1:0] min;
      logic signed [SAMPLE_W-1:0] max;
      logic                       ovf;
   } snap_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

[hw/rtl/msstat_front.sv]
// Front end: takes samples, keeps the running totals, emits one snapshot per run.
`timescale 1ns / 1ps
module msstat_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  msstat_pkg::req_type   req_data,
   input  msstat_pkg::q_status_type q_status,
   output logic                  push,
   output msstat_pkg::snap_type  snap
);

   logic                                   s1_valid_ff;
   msstat_pkg::req_type                    s1_req_ff;
   logic [31:0]                            s1_sq_ff;
   logic signed [31:0]                     smp_w;
   logic                                   adv;

   logic [msstat_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic signed [msstat_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [msstat_pkg::SQ_W-1:0]            sumsq_ff, sumsq_in;
   logic signed [msstat_pkg::SAMPLE_W-1:0] min_ff, min_in, max_ff, max_in;
   logic                                   ovf_ff, ovf_in;

   assign req_stall = s1_valid_ff && s1_req_ff.last_sample && q_status.full;
   assign adv       = s1_valid_ff && !(s1_req_ff.last_sample && q_status.full);
   assign smp_w     = 32'(req_data.sample);
   assign push      = adv && s1_req_ff.last_sample;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      ovf_in   = ovf_ff;
      if (adv && !s1_req_ff.masked) begin
         if (count_ff == msstat_pkg::COUNT_MAX) begin
            ovf_in = 1'b1;
         end else begin
            if (count_ff == '0 || s1_req_ff.sample < min_ff) min_in = s1_req_ff.sample;
            if (count_ff == '0 || s1_req_ff.sample > max_ff) max_in = s1_req_ff.sample;
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + msstat_pkg::SUM_W'(s1_req_ff.sample);
            sumsq_in = sumsq_ff + msstat_pkg::SQ_W'(s1_sq_ff);
         end
      end
   end

   always_comb begin
      snap.count = count_in;
      snap.sum   = sum_in;
      snap.sumsq = sumsq_in;
      snap.min   = (count_in == '0) ? '0 : min_in;
      snap.max   = (count_in == '0) ? '0 : max_in;
      snap.ovf   = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
         sumsq_ff    <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
            s1_req_ff   <= req_data;
            s1_sq_ff    <= 32'(smp_w * smp_w);
         end
         if (push) begin
            count_ff <= '0;
            sum_ff   <= '0;
            sumsq_ff <= '0;
            min_ff   <= '0;
            max_ff   <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            sumsq_ff <= sumsq_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

endmodule

[hw/rtl/msstat_queue.sv]
// Short snapshot queue between the front and the back.
`timescale 1ns / 1ps
module msstat_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  msstat_pkg::snap_type     push_data,
   input  logic                     pop,
   output msstat_pkg::snap_type     head,
   output msstat_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(msstat_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(msstat_pkg::Q_DEPTH + 1);

   msstat_pkg::snap_type mem_ff [msstat_pkg::Q_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     cnt_ff;

   assign head             = mem_ff[rd_ptr_ff];
   assign status.full      = (cnt_ff == CNT_W'(msstat_pkg::Q_DEPTH));
   assign status.not_empty = (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(msstat_pkg::Q_DEPTH - 1)) ? '0
                                                                               : wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= (rd_ptr_ff == PTR_W'(msstat_pkg::Q_DEPTH - 1)) ? '0
                                                                              : rd_ptr_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

[hw/rtl/msstat_back.sv]
// Back end: variance by shift-add, square root and divisions one bit per cycle.
`timescale 1ns / 1ps
module msstat_back (
   input  logic                     clock,
   input  logic                     reset,
   input  msstat_pkg::q_status_type q_status,
   input  msstat_pkg::snap_type     head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output msstat_pkg::rsp_type      rsp_data
);

   localparam int V_W   = 64;
   localparam int X_W   = 80;
   localparam int RT_W  = X_W / 2;
   localparam int SR_W  = RT_W + 2;
   localparam int DVD_W = msstat_pkg::SUM_W + msstat_pkg::FRAC_W + 1;
   localparam int DSR_W = msstat_pkg::COUNT_W + 1;
   localparam int STP_W = $clog2(DVD_W + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MULN, S_MULS, S_SQRT, S_DIVD, S_DIVA, S_DONE
   } state_type;

   state_type                              state_ff;
   logic [STP_W-1:0]                       step_ff;
   logic [msstat_pkg::COUNT_W-1:0]         n_ff;
   logic [msstat_pkg::SUM_W-1:0]           mag_ff;
   logic                                   neg_ff;
   logic signed [msstat_pkg::SUM_W-1:0]    sum_ff;
   logic signed [msstat_pkg::SAMPLE_W-1:0] min_ff, max_ff;
   logic                                   ovf_ff;
   logic [V_W-1:0]                         v_ff, ma_ff;
   logic [msstat_pkg::SUM_W-1:0]           mb_ff;
   logic [X_W-1:0]                         x_ff;
   logic [RT_W-1:0]                        root_ff;
   logic [SR_W-1:0]                        sq_rem_ff;
   logic [DVD_W-1:0]                       dvd_ff;
   logic [DSR_W-1:0]                       dsr_ff;
   logic [DSR_W-1:0]                       div_rem_ff;
   logic [msstat_pkg::FIX_W-1:0]           dev_ff;
   logic                                   rsp_valid_ff;
   msstat_pkg::rsp_type                    rsp_data_ff;

   logic [SR_W-1:0]  sr_t, sr_trial;
   logic             sr_ge;
   logic [DSR_W:0]   dr_t;
   logic             dr_ge;
   logic [msstat_pkg::FIX_W-1:0] q_lo;

   assign pop       = (state_ff == S_IDLE) && q_status.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sr_t     = {sq_rem_ff[SR_W-3:0], x_ff[X_W-1 -: 2]};
      sr_trial = {root_ff, 2'b01};
      sr_ge    = (sr_t >= sr_trial);
      dr_t     = {div_rem_ff, dvd_ff[DVD_W-1]};
      dr_ge    = (dr_t >= {1'b0, dsr_ff});
      q_lo     = dvd_ff[msstat_pkg::FIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_status.not_empty) begin
                  n_ff    <= head.count;
                  sum_ff  <= head.sum;
                  min_ff  <= head.min;
                  max_ff  <= head.max;
                  ovf_ff  <= head.ovf;
                  neg_ff  <= head.sum[msstat_pkg::SUM_W-1];
                  mag_ff  <= head.sum[msstat_pkg::SUM_W-1] ? msstat_pkg::SUM_W'(-head.sum)
                                                            : msstat_pkg::SUM_W'(head.sum);
                  v_ff    <= '0;
                  ma_ff   <= V_W'(head.sumsq);
                  mb_ff   <= msstat_pkg::SUM_W'(head.count);
                  step_ff <= STP_W'(msstat_pkg::COUNT_W - 1);
                  state_ff <= S_MULN;
               end
            end
            S_MULN: begin
               // n * sum of squares
               if (mb_ff[0]) v_ff <= v_ff + ma_ff;
               if (step_ff == '0) begin
                  ma_ff   <= V_W'(mag_ff);
                  mb_ff   <= mag_ff;
                  step_ff <= STP_W'(msstat_pkg::SUM_W - 1);
                  state_ff <= S_MULS;
               end else begin
                  ma_ff   <= ma_ff << 1;
                  mb_ff   <= mb_ff >> 1;
                  step_ff <= step_ff - 1'b1;
               end
            end
            S_MULS: begin
               // minus sum squared; stays non-negative throughout
               if (mb_ff[0]) v_ff <= v_ff - ma_ff;
               ma_ff <= ma_ff << 1;
               mb_ff <= mb_ff >> 1;
               if (step_ff == '0) begin
                  step_ff  <= STP_W'(RT_W - 1);
                  state_ff <= S_SQRT;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
               if (step_ff == '0) begin
                  x_ff      <= X_W'(mb_ff[0] ? (v_ff - ma_ff) : v_ff)
                               << (2 * msstat_pkg::FRAC_W);
                  root_ff   <= '0;
                  sq_rem_ff <= '0;
               end
            end
            S_SQRT: begin
               x_ff <= x_ff << 2;
               if (sr_ge) begin
                  sq_rem_ff <= sr_t - sr_trial;
                  root_ff   <= {root_ff[RT_W-2:0], 1'b1};
               end else begin
                  sq_rem_ff <= sr_t;
                  root_ff   <= {root_ff[RT_W-2:0], 1'b0};
               end
               if (step_ff == '0) begin
                  step_ff  <= STP_W'(DVD_W - 1);
                  state_ff <= S_DIVD;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
               if (step_ff == '0) begin
                  dvd_ff     <= DVD_W'({root_ff[RT_W-2:0], sr_ge});
                  dsr_ff     <= DSR_W'(n_ff);
                  div_rem_ff <= '0;
               end
            end
            S_DIVD, S_DIVA: begin
               if (step_ff == '0 && state_ff == S_DIVD) begin
                  dev_ff     <= {q_lo[msstat_pkg::FIX_W-2:0], dr_ge};
                  dvd_ff     <= (DVD_W'(mag_ff) << (msstat_pkg::FRAC_W + 1)) + DVD_W'(n_ff);
                  dsr_ff     <= {n_ff, 1'b0};
                  div_rem_ff <= '0;
                  step_ff    <= STP_W'(DVD_W - 1);
                  state_ff   <= S_DIVA;
               end else begin
                  div_rem_ff <= dr_ge ? DSR_W'(dr_t - {1'b0, dsr_ff}) : dr_t[DSR_W-1:0];
                  dvd_ff     <= {dvd_ff[DVD_W-2:0], dr_ge};
                  if (step_ff != '0) step_ff <= step_ff - 1'b1;
                  else state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.valid_count <= n_ff;
                  rsp_data_ff.total       <= sum_ff;
                  rsp_data_ff.smallest    <= min_ff;
                  rsp_data_ff.largest     <= max_ff;
                  rsp_data_ff.overflow    <= ovf_ff;
                  if (n_ff == '0) begin
                     rsp_data_ff.average   <= '0;
                     rsp_data_ff.deviation <= '0;
                  end else begin
                     rsp_data_ff.average   <= neg_ff ? (~q_lo + 1'b1) : q_lo;
                     rsp_data_ff.deviation <= dev_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/masked_stream_statistics_core.sv]
// Masked stream statistics: top level with front, snapshot queue and back.
//
// Input channel req_*: one sample per transfer (sample, masked, last_sample).
// Masked samples only count toward ending a run. The transfer with
// last_sample set closes the run; one result transfer follows on rsp_*
// with count, sum, min, max, mean and population deviation (8 fraction bits).
// The front takes one sample per cycle while req_stall is low, through a two-stage accumulator.
// Each closed run is queued (two entries) for the back, which takes one
// run at a time: a load, 16 + 32 shift-add steps for n*sumsq - sum^2,
// 40 square root steps, two 41-step restoring divisions and the output.
// The back pops the next run only after its result has been registered.
// req_stall rises only while a closed run waits for a full queue; the back
// holds its result in the output register while rsp_stall is high.
// Synchronous reset clears the running totals, the queue and the output valid.
`timescale 1ns / 1ps
`include "masked_stream_statistics_core_defines.svh"
module masked_stream_statistics_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  msstat_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output msstat_pkg::rsp_type rsp_data
);

   msstat_pkg::q_status_type q_status;
   msstat_pkg::snap_type     snap, head;
   logic                     push, pop;
   logic                     none_rsp, one_rsp, zero_stats;

   assign none_rsp   = rsp_valid && (rsp_data.valid_count == '0);
   assign one_rsp    = rsp_valid && (rsp_data.valid_count == msstat_pkg::COUNT_W'(1));
   assign zero_stats = (rsp_data.average == '0) && (rsp_data.deviation == '0);

   msstat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .snap      (snap)
   );

   msstat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (snap),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   msstat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `MSSTAT_ASSERT_IMPL(a_no_push_full, clock, reset, push, !q_status.full || pop)
   `MSSTAT_ASSERT_IMPL(a_empty_zero, clock, reset, none_rsp, zero_stats)
   `MSSTAT_ASSERT_IMPL(a_single_dev, clock, reset, one_rsp, rsp_data.deviation == '0)
   `MSSTAT_ASSERT_NEXT(a_pop_empties, clock, reset, pop && !push && q_status.full, !q_status.full)

endmodule

[tb/masked_stream_statistics_core_tb.sv]
// Self-checking testbench for the masked stream statistics core.
`timescale 1ns / 1ps
module masked_stream_statistics_core_tb;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   msstat_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   msstat_pkg::rsp_type rsp_data;

   masked_stream_statistics_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   msstat_pkg::req_type pending_samples[$];
   msstat_pkg::rsp_type expected_stats[$];
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatches = 0;
   longint      cycles = 0;

   // running totals of the open run
   longint      acc_count = 0;
   longint      acc_sum = 0;
   longint      acc_sumsq = 0;
   longint      acc_min = 0;
   longint      acc_max = 0;
   bit          acc_ovf = 0;

   task automatic accumulate_sample(input msstat_pkg::req_type it);
      longint      s, n, mag, q;
      logic [127:0] v, sq;
      logic [63:0] root, c;
      msstat_pkg::rsp_type r;
      s = longint'(it.sample);
      if (!it.masked) begin
         if (acc_count >= longint'(msstat_pkg::COUNT_MAX)) begin
            acc_ovf = 1;
         end else begin
            if (acc_count == 0 || s < acc_min) acc_min = s;
            if (acc_count == 0 || s > acc_max) acc_max = s;
            acc_count++;
            acc_sum += s;
            acc_sumsq += s * s;
         end
      end
      if (!it.last_sample) return;
      n = acc_count;
      r = '0;
      r.valid_count = n[msstat_pkg::COUNT_W-1:0];
      r.total = acc_sum[msstat_pkg::SUM_W-1:0];
      r.overflow = acc_ovf;
      if (n > 0) begin
         r.smallest = acc_min[msstat_pkg::SAMPLE_W-1:0];
         r.largest = acc_max[msstat_pkg::SAMPLE_W-1:0];
         mag = acc_sum < 0 ? -acc_sum : acc_sum;
         q = (2 * (mag << msstat_pkg::FRAC_W) + n) / (2 * n);
         if (acc_sum < 0) q = -q;
         r.average = q[msstat_pkg::FIX_W-1:0];
      end
      if (n > 1) begin
         v = (128'(n) * 128'(acc_sumsq) - 128'(acc_sum * acc_sum)) << (2 * msstat_pkg::FRAC_W);
         root = '0;
         for (int b = 63; b >= 0; b--) begin
            c = root | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= v) root = c;
         end
         root = root / 64'(n);
         r.deviation = root[msstat_pkg::FIX_W-1:0];
      end
      expected_stats.push_back(r);
      acc_count = 0;
      acc_sum = 0;
      acc_sumsq = 0;
      acc_min = 0;
      acc_max = 0;
      acc_ovf = 0;
   endtask

   // driver: head of the queue is the sample on the bus
   always @(posedge clock) begin
      msstat_pkg::req_type nd;
      logic    nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            accumulate_sample(pending_samples.pop_front());
         end
         nv = 1'b0;
         nd = req_data;
         if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            nv = 1'b1;
            nd = pending_samples[0];
         end
         req_valid <= nv;
         req_data <= nd;
      end
   end

   // monitor
   always @(posedge clock) begin
      msstat_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               e = expected_stats.pop_front();
               if (rsp_data.valid_count !== e.valid_count || rsp_data.total !== e.total ||
                   rsp_data.smallest !== e.smallest || rsp_data.largest !== e.largest ||
                   rsp_data.average !== e.average || rsp_data.deviation !== e.deviation ||
                   rsp_data.overflow !== e.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result differs: expected %p got %p", e, rsp_data);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("masked_stream_statistics_core: mismatch");
         $finish;
      end
   end

   function automatic msstat_pkg::req_type make_sample(logic signed [15:0] s, bit m, bit l);
      msstat_pkg::req_type it;
      it.sample = s;
      it.masked = m;
      it.last_sample = l;
      return it;
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random_runs(input int items);
      int len, kind;
      bit mask_all;
      while (items > 0) begin
         kind = $urandom_range(19);
         len = (kind == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
         mask_all = ($urandom_range(15) == 0);
         for (int i = 0; i < len; i++) begin
            pending_samples.push_back(make_sample(pick_value(),
               mask_all || ($urandom_range(3) == 0), i == len - 1));
         end
         items -= len;
      end
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: single samples, empty runs, masked last, extremes
      pending_samples.push_back(make_sample(16'sh7fff, 0, 1));
      pending_samples.push_back(make_sample(16'sh8000, 0, 1));
      pending_samples.push_back(make_sample(16'sh1234, 1, 1));
      pending_samples.push_back(make_sample(16'sh0005, 1, 0));
      pending_samples.push_back(make_sample(16'sh0006, 1, 1));
      pending_samples.push_back(make_sample(16'sh7fff, 0, 0));
      pending_samples.push_back(make_sample(16'sh8000, 0, 1));
      pending_samples.push_back(make_sample(16'sh0001, 0, 0));
      pending_samples.push_back(make_sample(16'sh0000, 0, 1));
      pending_samples.push_back(make_sample(-16'sd3, 0, 0));
      pending_samples.push_back(make_sample(-16'sd4, 0, 0));
      pending_samples.push_back(make_sample(16'sh7fff, 1, 0));
      pending_samples.push_back(make_sample(-16'sd4, 1, 1));
      pending_samples.push_back(make_sample(16'sh0007, 0, 0));
      pending_samples.push_back(make_sample(16'sh0007, 0, 0));
      pending_samples.push_back(make_sample(16'sh0007, 0, 1));
      wait_drained();

      queue_random_runs(480);
      wait_drained();

      sender_idle_pct = 65;
      queue_random_runs(480);
      wait_drained();

      sender_idle_pct = 0;
      receiver_stall_pct = 65;
      queue_random_runs(480);
      wait_drained();

      sender_idle_pct = 28;
      receiver_stall_pct = 28;
      queue_random_runs(480);
      wait_drained();

      if (mismatches == 0 && expected_stats.size() == 0)
         $display("masked_stream_statistics_core: match");
      else
         $display("masked_stream_statistics_core: mismatch");
      $finish;
   end

endmodule
